// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define FDS_ASSERT_IMPL(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define FDS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Property checked at every edge, reset included.
`define FDS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/fds_pkg.sv -----
`default_nettype none

package fds_pkg;

  // Size limits
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  // Field widths
  localparam int FLOW_W  = 16;
  localparam int WORD_W  = 2 * FLOW_W;
  localparam int LEVEL_W = 8;
  localparam int SIZE_W  = 10;
  localparam int GAIN_W  = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV_GAIN     = 2'd2;

  // Register reset values
  localparam int                LINE_WIDTH_RST   = 512;
  localparam int                FRAME_HEIGHT_RST = 512;
  localparam logic [GAIN_W-1:0] DIV_GAIN_RST     = 24'd8355840;

  // Smallest frame side
  localparam int MIN_SIZE = 3;

  // Divergence: at most 2^19 in magnitude, plus sign
  localparam int DD_W  = 21;
  // dd * gain + offset
  localparam int ACC_W = DD_W + GAIN_W + 2;
  // 127.5 in gray levels, scaled by 2^24
  localparam logic signed [ACC_W-1:0] LEVEL_OFFSET = ACC_W'(64'd255 << 23);
  localparam logic [LEVEL_W-1:0]      LEVEL_MAX    = 8'd255;

  // Flags of one window position, carried next to its data
  typedef struct packed {
    logic emit;
    logic fend;
    logic lv;
    logic rv;
    logic tv;
    logic bv;
  } win_ctl_t;

  function automatic logic signed [DD_W-1:0] sx16(input logic [FLOW_W-1:0] x);
    return {{(DD_W - FLOW_W){x[FLOW_W-1]}}, x};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/flow_divergence_sobel_top.sv -----
// The item that completes a 3x3 window (one row plus one pixel after its centre)
//   passes stage 1, stage 2 and the result register. Throughput: 1 item per cycle
//   while not stalled; each line store is read and written once per item.
// Reset (rst_ni low, async): pipeline and counters cleared, registers back to
//   their reset values, window zeroed; line stores are not cleared.
`default_nettype none

module flow_divergence_sobel_top #(
  parameter int MAX_WIDTH  = fds_pkg::MAX_WIDTH,
  parameter int MAX_HEIGHT = fds_pkg::MAX_HEIGHT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // configuration
  input  wire logic                             cfg_we_i,
  input  wire logic [fds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fds_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // flow items
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [fds_pkg::FLOW_W-1:0]       flow_x_i,
  input  wire logic [fds_pkg::FLOW_W-1:0]       flow_y_i,
  input  wire logic                             pad_i,
  // gray results
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [fds_pkg::LEVEL_W-1:0]           level_o,
  output logic                                  frame_end_o
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 3);
  localparam int WCW = (CW > fds_pkg::SIZE_W) ? CW : fds_pkg::SIZE_W;
  localparam int HCW = (HW > fds_pkg::SIZE_W) ? HW : fds_pkg::SIZE_W;
  localparam int WW  = fds_pkg::WORD_W;
  localparam int FW  = fds_pkg::FLOW_W;
  localparam int DDW = fds_pkg::DD_W;
  localparam int ACW = fds_pkg::ACC_W;

  localparam int W_RST = (fds_pkg::LINE_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                               : fds_pkg::LINE_WIDTH_RST;
  localparam int H_RST = (fds_pkg::FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT
                                                                  : fds_pkg::FRAME_HEIGHT_RST;

  // ---------------------------------------------------------------- config
  logic [CW-1:0]              w_q, w_d;
  logic [HW-1:0]              h_q, h_d;
  logic [fds_pkg::GAIN_W-1:0] gain_q;
  logic [WCW-1:0]             lw_ext;
  logic [HCW-1:0]             fh_ext;
  logic                       size_wr;

  // sizes are stored already clamped to 3..MAX
  always_comb begin
    lw_ext = WCW'(cfg_data_i[fds_pkg::SIZE_W-1:0]);
    fh_ext = HCW'(cfg_data_i[fds_pkg::SIZE_W-1:0]);
    if (lw_ext < WCW'(fds_pkg::MIN_SIZE)) begin
      w_d = CW'(fds_pkg::MIN_SIZE);
    end else if (lw_ext > WCW'(MAX_WIDTH)) begin
      w_d = CW'(MAX_WIDTH);
    end else begin
      w_d = lw_ext[CW-1:0];
    end
    if (fh_ext < HCW'(fds_pkg::MIN_SIZE)) begin
      h_d = HW'(fds_pkg::MIN_SIZE);
    end else if (fh_ext > HCW'(MAX_HEIGHT)) begin
      h_d = HW'(MAX_HEIGHT);
    end else begin
      h_d = fh_ext[HW-1:0];
    end
  end

  assign size_wr = cfg_we_i && (cfg_index_i == fds_pkg::CFG_LINE_WIDTH ||
                                cfg_index_i == fds_pkg::CFG_FRAME_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= CW'(W_RST);
      h_q    <= HW'(H_RST);
      gain_q <= fds_pkg::DIV_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fds_pkg::CFG_LINE_WIDTH:   w_q    <= w_d;
        fds_pkg::CFG_FRAME_HEIGHT: h_q    <= h_d;
        fds_pkg::CFG_DIV_GAIN:     gain_q <= cfg_data_i[fds_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  logic p1_valid_q, p2_valid_q, out_valid_q;
  logic out_free, p2_free, p1_adv, p1_free, in_acc;
  fds_pkg::win_ctl_t p1_ctl_q, ctl_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign p2_free    = !p2_valid_q || out_free;
  assign p1_adv     = p1_valid_q && (!p1_ctl_q.emit || p2_free);
  assign p1_free    = !p1_valid_q || p1_adv;
  assign in_stall_o = !p1_free;
  assign in_acc     = in_valid_i && p1_free;

  // ------------------------------------------------------ stream position
  logic [CW-1:0] col_q, col_e, col_inc;
  logic [RW-1:0] row_q, row_inc, h_ext;
  logic          col_nz, wrap, restart;

  always_comb begin
    h_ext   = RW'(h_q);
    col_e   = (col_q >= w_q) ? '0 : col_q;
    col_nz  = (col_e != '0);
    col_inc = col_e + CW'(1);
    wrap    = (col_inc >= w_q);
    row_inc = wrap ? row_q + RW'(1) : row_q;

    // centre is (col-1, row-1), or (w-1, row-2) on the first column
    if (col_nz) begin
      ctl_d.emit = (row_q >= RW'(1)) && (row_q <= h_ext);
      ctl_d.tv   = (row_q > RW'(1));
      ctl_d.bv   = (row_q < h_ext);
      ctl_d.lv   = (col_e > CW'(1));
    end else begin
      ctl_d.emit = (row_q >= RW'(2)) && (row_q <= h_ext + RW'(1));
      ctl_d.tv   = (row_q > RW'(2));
      ctl_d.bv   = (row_q < h_ext + RW'(1));
      ctl_d.lv   = 1'b1;
    end
    ctl_d.rv   = col_nz;
    ctl_d.fend = ctl_d.emit && !col_nz && (row_q == h_ext + RW'(1));
    restart    = ctl_d.fend || (row_inc > h_ext + RW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (size_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (restart) begin
        col_q <= '0;
        row_q <= '0;
      end else begin
        col_q <= wrap ? '0 : col_inc;
        row_q <= row_inc;
      end
    end
  end

  // ----------------------------------------------------------- line stores
  logic [WW-1:0] older_mem [MAX_WIDTH];
  logic [WW-1:0] newer_mem [MAX_WIDTH];
  logic [WW-1:0] nt_q, nm_q;
  logic [WW-1:0] in_word;
  logic [AW-1:0] rd_addr;

  assign in_word = pad_i ? '0 : {flow_y_i, flow_x_i};
  assign rd_addr = col_e[AW-1:0];

  logic [WW-1:0] p1_word_q;
  logic [AW-1:0] p1_addr_q;

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      older_mem[p1_addr_q] <= nm_q;
    end
    if (in_acc) begin
      nt_q <= older_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_adv) begin
      newer_mem[p1_addr_q] <= p1_word_q;
    end
    if (in_acc) begin
      nm_q <= newer_mem[rd_addr];
    end
  end

  // ------------------------------------------------------ stage 1: window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (p1_free) begin
      p1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_word_q <= in_word;
      p1_addr_q <= rd_addr;
      p1_ctl_q  <= ctl_d;
    end
  end

  // two columns before the newest: [0..2] left, [3..5] centre, top to bottom
  logic [WW-1:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (p1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= nt_q;
      win_q[4] <= nm_q;
      win_q[5] <= p1_word_q;
    end
  end

  logic signed [DDW-1:0] xx, yy, dd;

  always_comb begin
    xx = '0;
    yy = '0;
    if (p1_ctl_q.lv) begin
      xx = xx - (p1_ctl_q.tv ? fds_pkg::sx16(win_q[0][FW-1:0]) : '0)
              - (fds_pkg::sx16(win_q[1][FW-1:0]) <<< 1)
              - (p1_ctl_q.bv ? fds_pkg::sx16(win_q[2][FW-1:0]) : '0);
      yy = yy + (p1_ctl_q.bv ? fds_pkg::sx16(win_q[2][WW-1:FW]) : '0)
              - (p1_ctl_q.tv ? fds_pkg::sx16(win_q[0][WW-1:FW]) : '0);
    end
    if (p1_ctl_q.rv) begin
      xx = xx + (p1_ctl_q.tv ? fds_pkg::sx16(nt_q[FW-1:0]) : '0)
              + (fds_pkg::sx16(nm_q[FW-1:0]) <<< 1)
              + (p1_ctl_q.bv ? fds_pkg::sx16(p1_word_q[FW-1:0]) : '0);
      yy = yy + (p1_ctl_q.bv ? fds_pkg::sx16(p1_word_q[WW-1:FW]) : '0)
              - (p1_ctl_q.tv ? fds_pkg::sx16(nt_q[WW-1:FW]) : '0);
    end
    if (p1_ctl_q.tv) begin
      yy = yy - (fds_pkg::sx16(win_q[3][WW-1:FW]) <<< 1);
    end
    if (p1_ctl_q.bv) begin
      yy = yy + (fds_pkg::sx16(win_q[5][WW-1:FW]) <<< 1);
    end
    dd = xx + yy;
  end

  // ---------------------------------------------------- stage 2: divergence
  logic signed [DDW-1:0] p2_dd_q;
  logic                  p2_fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_valid_q <= 1'b0;
    end else if (p2_free) begin
      p2_valid_q <= p1_adv && p1_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_free && p1_adv && p1_ctl_q.emit) begin
      p2_dd_q   <= dd;
      p2_fend_q <= p1_ctl_q.fend;
    end
  end

  // ------------------------------------------------ gray mapping and clamp
  logic signed [ACW-1:0] acc;
  logic [fds_pkg::LEVEL_W-1:0] level_d;

  always_comb begin
    acc = ACW'(p2_dd_q * $signed({1'b0, gain_q})) + fds_pkg::LEVEL_OFFSET;
    if (acc[ACW-1]) begin
      level_d = '0;
    end else if (|acc[ACW-2:24+fds_pkg::LEVEL_W]) begin
      level_d = fds_pkg::LEVEL_MAX;
    end else begin
      level_d = acc[24+fds_pkg::LEVEL_W-1:24];
    end
  end

  logic [fds_pkg::LEVEL_W-1:0] level_q;
  logic                        fend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && p2_valid_q) begin
      level_q <= level_d;
      fend_q  <= p2_fend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign level_o     = level_q;
  assign frame_end_o = fend_q;

endmodule

`default_nettype wire

// ----- rtl/fds_checker.sv -----
`default_nettype none
`include "assert_macros.svh"

module fds_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           in_stall_o,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [fds_pkg::LEVEL_W-1:0]    level_o,
  input wire logic                           frame_end_o
);

  // input side only backs up when the result register is full and stalled
  `FDS_ASSERT_IMPL(a_stall_backs_up, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled while the result side can move")

  // a stalled result stays offered
  `FDS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")

  // and keeps its payload
  `FDS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(level_o) && $stable(frame_end_o), "result changed while stalled")

  // the cycle after reset shows an empty pipeline
  `FDS_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (!out_valid_o && !in_stall_o), "pipeline not empty after reset")

endmodule

bind flow_divergence_sobel_top fds_checker u_fds_checker (.*);

`default_nettype wire
